// File: rtl/awss_pkg.sv
// Shared types and constants of the acoustic wave stencil step block.
// Holds the payload structs, item function codes, the configuration register
// map and the command/status structs between controller and datapath.
package awss_pkg;

  // Default grid limits; MAX_ROWS_DEF sizes the line store and the delay store.
  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 4096;

  // Field and register widths
  localparam int P_W        = 32;
  localparam int V_W        = 16;
  localparam int GAIN_W     = 32;
  localparam int COLS_W     = 13;
  localparam int ROWS_W     = 11;
  localparam int THR_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Item function codes
  localparam logic FUNC_POINT = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_COEF        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_THRESHOLD = 2'd3;

  // Configuration reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = '0;
  localparam logic [COLS_W-1:0] COLS_RST = 13'd3;
  localparam logic [ROWS_W-1:0] ROWS_RST = 11'd3;
  localparam logic [THR_W-1:0]  THR_RST  = '0;

  typedef struct packed {
    logic                  func;
    logic signed [P_W-1:0] cur_pressure;
    logic signed [P_W-1:0] prev_pressure;
    logic [V_W-1:0]        velocity;
  } point_t;

  typedef struct packed {
    logic signed [P_W-1:0] next_pressure;
    logic                  grid_end;
  } result_t;

  // Controller to datapath: strobes for the sequencer steps
  typedef struct packed {
    logic clear_step;
    logic load;
    logic rd0;
    logic rd1;
    logic rd2;
    logic rd3;
    logic mag;
    logic mul0;
    logic mul1;
    logic sum;
    logic fin;
    logic emit;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic emit_now;
    logic noop;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/awss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the pressure line store and the p2/velocity delay store.
// No package dependencies.
module awss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/awss_ctrl.sv
// Sequencer of the acoustic wave stencil step block.
// Steps the datapath through clear, read, multiply and emit phases.
// Depends on awss_pkg (cmd_t, sts_t).
module awss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  input  awss_pkg::sts_t  sts,
  output logic            point_stall,
  output awss_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_RD2   = 4'd4;
  localparam logic [3:0] S_RD3   = 4'd5;
  localparam logic [3:0] S_MAG   = 4'd6;
  localparam logic [3:0] S_MUL0  = 4'd7;
  localparam logic [3:0] S_MUL1  = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_WRITE = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign point_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (point_valid) begin
          cmd.load = 1'b1;
          if (sts.emit_now) begin
            state_next = S_RD0;
          end else if (sts.noop) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_RD0: begin
        cmd.rd0    = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd1    = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd2    = 1'b1;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.rd3    = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/awss_dpath.sv
// Datapath of the acoustic wave stencil step block: configuration registers,
// line and delay stores, address pointers, counters, shared multiplier and
// result register. Depends on awss_pkg and awss_ram.
module awss_dpath #(
  parameter int MAX_ROWS = awss_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = awss_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [awss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [awss_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  awss_pkg::point_t                    point,
  output awss_pkg::result_t                   result,
  output logic                                result_valid,
  input  logic                                result_stall,
  input  awss_pkg::cmd_t                      cmd,
  output awss_pkg::sts_t                      sts
);

  localparam int P_W         = awss_pkg::P_W;
  localparam int V_W         = awss_pkg::V_W;
  localparam int LINE_DEPTH  = 2 * MAX_ROWS + 2;
  localparam int LAW         = $clog2(LINE_DEPTH);
  localparam int DELAY_DEPTH = MAX_ROWS + 1;
  localparam int DAW         = $clog2(DELAY_DEPTH);
  localparam int DW          = P_W + V_W;
  localparam int PW          = $clog2(MAX_ROWS + 2);
  localparam int RW          = $clog2(MAX_ROWS + 1);
  localparam int CW          = $clog2(MAX_COLS + 1);
  localparam int TW          = $clog2(MAX_ROWS);
  localparam int XW          = $clog2(MAX_COLS);
  localparam int LAP_W       = 36;
  localparam int MAG_W       = 35;
  localparam int BASE_W      = 34;
  localparam int MA_W        = 32;
  localparam int MP_W        = MA_W + MAG_W;
  localparam int S_W         = MP_W + 1;
  localparam int Q_W         = S_W - 16;
  localparam int T_W         = Q_W + 1;
  localparam int TOT_W       = T_W + 1;

  function automatic logic [P_W-1:0] abs_p(input logic [P_W-1:0] x);
    logic [P_W-1:0] neg;
    neg   = -x;
    abs_p = x[P_W-1] ? neg : x;
  endfunction

  function automatic logic [LAP_W-1:0] sx_lap(input logic [P_W-1:0] x);
    sx_lap = {{(LAP_W-P_W){x[P_W-1]}}, x};
  endfunction

  // configuration
  logic [awss_pkg::GAIN_W-1:0] gain_coef;
  logic [awss_pkg::COLS_W-1:0] grid_cols;
  logic [awss_pkg::ROWS_W-1:0] grid_rows;
  logic [awss_pkg::THR_W-1:0]  active_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_coef        <= awss_pkg::GAIN_RST;
      grid_cols        <= awss_pkg::COLS_RST;
      grid_rows        <= awss_pkg::ROWS_RST;
      active_threshold <= awss_pkg::THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        awss_pkg::CFG_GAIN_COEF:        gain_coef <= cfg_data[awss_pkg::GAIN_W-1:0];
        awss_pkg::CFG_GRID_COLS:        grid_cols <= cfg_data[awss_pkg::COLS_W-1:0];
        awss_pkg::CFG_GRID_ROWS:        grid_rows <= cfg_data[awss_pkg::ROWS_W-1:0];
        awss_pkg::CFG_ACTIVE_THRESHOLD: active_threshold <= cfg_data[awss_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the grid sizes to the supported range
  logic [31:0]   rows_wide;
  logic [31:0]   cols_wide;
  logic [RW-1:0] eff_rows;
  logic [CW-1:0] eff_cols;

  assign rows_wide = 32'(grid_rows);
  assign cols_wide = 32'(grid_cols);
  assign eff_rows  = (rows_wide < 32'd3) ? RW'(3) :
                     (rows_wide > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_wide);
  assign eff_cols  = (cols_wide < 32'd3) ? CW'(3) :
                     (cols_wide > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_wide);

  // pointers and counters
  logic [LAW-1:0] line_wp;
  logic [DAW-1:0] delay_wp;
  logic [PW-1:0]  pending;
  logic [TW-1:0]  row_cnt;
  logic [XW-1:0]  col_cnt;
  logic [LAW-1:0] clear_addr;
  logic           pend_full;

  assign pend_full    = 32'(pending) >= (32'(eff_rows) + 32'd1);
  assign sts.emit_now = point.func ? (pending != '0) : pend_full;
  assign sts.noop     = point.func && (pending == '0);
  assign sts.clear_last = (clear_addr == LAW'(LINE_DEPTH - 1));

  // latched item
  logic                  func_r;
  logic                  emit_r;
  logic [P_W-1:0]        cur_r;
  logic [P_W-1:0]        prev_r;
  logic [V_W-1:0]        vel_r;

  // address of the oldest pending point in both rings
  logic [LAW:0]   wp_ext;
  logic [LAW:0]   pend_l;
  logic [LAW:0]   c_calc;
  logic [DAW:0]   dwp_ext;
  logic [DAW:0]   pend_d;
  logic [DAW:0]   d_calc;

  assign wp_ext  = {1'b0, line_wp};
  assign pend_l  = (LAW+1)'(pending);
  assign c_calc  = (wp_ext >= pend_l) ? (wp_ext - pend_l)
                                      : (wp_ext + (LAW+1)'(LINE_DEPTH) - pend_l);
  assign dwp_ext = {1'b0, delay_wp};
  assign pend_d  = (DAW+1)'(pending);
  assign d_calc  = (dwp_ext >= pend_d) ? (dwp_ext - pend_d)
                                       : (dwp_ext + (DAW+1)'(DELAY_DEPTH) - pend_d);

  logic [LAW-1:0] c_addr;
  logic [DAW-1:0] d_addr;
  logic [LAW-1:0] a_p1;
  logic [LAW-1:0] a_rt;
  logic [LAW-1:0] a_lf;

  // neighbor addresses, modulo the ring depth
  logic [LAW-1:0] c_m1;
  logic [LAW-1:0] c_p1;
  logic [LAW:0]   rows_l;
  logic [LAW:0]   c_ext;
  logic [LAW:0]   rt_sum;
  logic [LAW:0]   rt_calc;
  logic [LAW:0]   lf_calc;

  assign c_m1    = (c_addr == '0) ? LAW'(LINE_DEPTH - 1) : (c_addr - LAW'(1));
  assign c_p1    = (c_addr == LAW'(LINE_DEPTH - 1)) ? '0 : (c_addr + LAW'(1));
  assign rows_l  = (LAW+1)'(eff_rows);
  assign c_ext   = {1'b0, c_addr};
  assign rt_sum  = c_ext + rows_l;
  assign rt_calc = (rt_sum >= (LAW+1)'(LINE_DEPTH)) ? (rt_sum - (LAW+1)'(LINE_DEPTH)) : rt_sum;
  assign lf_calc = (c_ext >= rows_l) ? (c_ext - rows_l)
                                     : (c_ext + (LAW+1)'(LINE_DEPTH) - rows_l);

  // stores
  logic           line_we;
  logic [LAW-1:0] line_waddr;
  logic [P_W-1:0] line_wdata;
  logic [LAW-1:0] raddr_a;
  logic [LAW-1:0] raddr_b;
  logic [P_W-1:0] rd_a;
  logic [P_W-1:0] rd_b;
  logic           delay_we;
  logic [DW-1:0]  delay_rd;

  assign line_we    = cmd.clear_step || (cmd.commit && !func_r);
  assign line_waddr = cmd.clear_step ? clear_addr : line_wp;
  assign line_wdata = cmd.clear_step ? '0 : cur_r;
  assign delay_we   = cmd.commit && !func_r;

  always_comb begin
    raddr_a = c_addr;
    raddr_b = c_m1;
    if (cmd.rd1) begin
      raddr_a = a_p1;
      raddr_b = a_rt;
    end else if (cmd.rd2) begin
      raddr_a = a_lf;
      raddr_b = a_lf;
    end
  end

  awss_ram #(.WIDTH(P_W), .DEPTH(LINE_DEPTH)) u_line_a (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  awss_ram #(.WIDTH(P_W), .DEPTH(LINE_DEPTH)) u_line_b (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  awss_ram #(.WIDTH(DW), .DEPTH(DELAY_DEPTH)) u_delay (
    .clk   (clk),
    .we    (delay_we),
    .waddr (delay_wp),
    .wdata ({prev_r, vel_r}),
    .raddr (d_addr),
    .rdata (delay_rd)
  );

  // stencil operands and intermediate results
  logic [P_W-1:0]    p1_q;
  logic [P_W-1:0]    p2_q;
  logic [V_W-1:0]    vel_q;
  logic [P_W-1:0]    up_q;
  logic [P_W-1:0]    dn_q;
  logic [P_W-1:0]    rt_q;
  logic [LAP_W-1:0]  part0;
  logic [LAP_W-1:0]  lap;
  logic [LAP_W-1:0]  lap_negated;
  logic [BASE_W-1:0] base;
  logic              active;
  logic              hit;
  logic              neg;
  logic [MAG_W-1:0]  mag_q;
  logic [31:0]       vv;
  logic [63:0]       k;
  logic [MP_W-1:0]   prod0;
  logic [MP_W-1:0]   prod1;
  logic [S_W-1:0]    s;
  logic              sticky;
  logic [T_W-1:0]    t;

  logic [P_W-1:0]    thr_ext;
  logic              act_now;
  logic              interior;
  logic              last_row;
  logic              last_col;

  assign thr_ext = {1'b0, active_threshold};
  assign act_now = (abs_p(p2_q) > thr_ext) || (abs_p(dn_q) > thr_ext) ||
                   (abs_p(up_q) > thr_ext) || (abs_p(rt_q) > thr_ext) ||
                   (abs_p(rd_a) > thr_ext);
  assign lap_negated = -lap;

  assign interior = (row_cnt != '0) && ((32'(row_cnt) + 32'd2) <= 32'(eff_rows)) &&
                    (col_cnt != '0) && ((32'(col_cnt) + 32'd2) <= 32'(eff_cols));
  assign last_row = (32'(row_cnt) + 32'd1) >= 32'(eff_rows);
  assign last_col = (32'(col_cnt) + 32'd1) >= 32'(eff_cols);

  // shared multiplier: v*v, gain*v^2, then the two halves of k*|lap|
  logic [MA_W-1:0]  mul_a;
  logic [MAG_W-1:0] mul_b;
  logic [MP_W-1:0]  mul_p;

  always_comb begin
    mul_a = MA_W'(vel_q);
    mul_b = MAG_W'(vel_q);
    if (cmd.mag) begin
      mul_a = gain_coef;
      mul_b = MAG_W'(vv);
    end else if (cmd.mul0) begin
      mul_a = k[31:0];
      mul_b = mag_q;
    end else if (cmd.mul1) begin
      mul_a = k[63:32];
      mul_b = mag_q;
    end
  end

  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

  // floor of the scaled product, then the signed sum and saturation
  logic [Q_W-1:0]   q;
  logic             frac_nz;
  logic [TOT_W-1:0] total;
  logic             fits;
  logic [P_W-1:0]   sat;
  logic [P_W-1:0]   res_val;

  assign q       = s[S_W-1:16];
  assign frac_nz = sticky || (s[15:0] != '0);
  assign total   = {t[T_W-1], t} + {{(TOT_W-BASE_W){base[BASE_W-1]}}, base};
  assign fits    = (&total[TOT_W-1:P_W-1]) || !(|total[TOT_W-1:P_W-1]);
  assign sat     = fits ? total[P_W-1:0] :
                   (total[TOT_W-1] ? {1'b1, {(P_W-1){1'b0}}} : {1'b0, {(P_W-1){1'b1}}});
  assign res_val = hit ? sat : p1_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= point.func;
      emit_r <= sts.emit_now;
      cur_r  <= point.cur_pressure;
      prev_r <= point.prev_pressure;
      vel_r  <= point.velocity;
      c_addr <= c_calc[LAW-1:0];
      d_addr <= d_calc[DAW-1:0];
    end
    if (cmd.rd0) begin
      a_p1 <= c_p1;
      a_rt <= rt_calc[LAW-1:0];
      a_lf <= lf_calc[LAW-1:0];
    end
    if (cmd.rd1) begin
      p1_q  <= rd_a;
      up_q  <= rd_b;
      p2_q  <= delay_rd[DW-1:V_W];
      vel_q <= delay_rd[V_W-1:0];
    end
    if (cmd.rd2) begin
      dn_q  <= rd_a;
      rt_q  <= rd_b;
      part0 <= sx_lap(up_q) + sx_lap(rd_b) -
               {{(LAP_W-P_W-2){p1_q[P_W-1]}}, p1_q, 2'b00};
      base  <= {p1_q[P_W-1], p1_q, 1'b0} - {{(BASE_W-P_W){p2_q[P_W-1]}}, p2_q};
      vv    <= mul_p[31:0];
    end
    if (cmd.rd3) begin
      lap    <= part0 + sx_lap(dn_q) + sx_lap(rd_a);
      active <= act_now;
    end
    if (cmd.mag) begin
      neg   <= lap[LAP_W-1];
      mag_q <= lap[LAP_W-1] ? lap_negated[MAG_W-1:0] : lap[MAG_W-1:0];
      k     <= mul_p[63:0];
      hit   <= active && interior;
    end
    if (cmd.mul0) begin
      prod0 <= mul_p;
    end
    if (cmd.mul1) begin
      prod1 <= mul_p;
    end
    if (cmd.sum) begin
      s      <= S_W'(prod1) + S_W'(prod0[MP_W-1:32]);
      sticky <= (prod0[31:0] != '0);
    end
    if (cmd.fin) begin
      // negative laplacian: -(q + frac) rounds toward minus infinity
      t <= neg ? (~{1'b0, q} + T_W'(!frac_nz)) : {1'b0, q};
    end
    if (cmd.emit) begin
      result.next_pressure <= res_val;
      result.grid_end      <= last_row && last_col;
    end
  end

  assign sts.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_wp      <= '0;
      delay_wp     <= '0;
      pending      <= '0;
      row_cnt      <= '0;
      col_cnt      <= '0;
      clear_addr   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clear_addr <= sts.clear_last ? '0 : (clear_addr + LAW'(1));
      end
      if (cmd.commit) begin
        if (func_r) begin
          pending <= pending - PW'(1);
        end else begin
          if (!emit_r) begin
            pending <= pending + PW'(1);
          end
          line_wp  <= (line_wp == LAW'(LINE_DEPTH - 1)) ? '0 : (line_wp + LAW'(1));
          delay_wp <= (delay_wp == DAW'(DELAY_DEPTH - 1)) ? '0 : (delay_wp + DAW'(1));
        end
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
        if (last_row) begin
          row_cnt <= '0;
          col_cnt <= last_col ? '0 : (col_cnt + XW'(1));
        end else begin
          row_cnt <= row_cnt + TW'(1);
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/acoustic_wave_stencil_step_core.sv
// Acoustic wave stencil step core. An emitting item (a grid point with a full
// pipe, or a flush with results pending) runs its read, multiply and emit
// steps before the next transfer is taken; a grid point that only fills the
// pipe takes a write step, an empty flush none. The sequencer walks line store
// reads, then four passes through one shared multiplier. Synchronous reset
// clears control state and then sweeps all 2*MAX_ROWS+2 line store entries.
module acoustic_wave_stencil_step_core #(
  parameter int MAX_ROWS = awss_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = awss_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [awss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awss_pkg::CFG_DATA_W-1:0] cfg_data,
  // grid point / flush channel
  input  logic                            point_valid,
  output logic                            point_stall,
  input  awss_pkg::point_t                point,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output awss_pkg::result_t               result
);

  // Data flow per item:
  //   - a grid point is written into the pressure line store (p1) and the
  //     p2/velocity delay store; once rows+1 points are pending, each new
  //     grid point first emits the oldest pending point
  //   - a flush emits the oldest pending point without writing anything
  //   - emitting reads p1 and its four neighbors from two copies of the line
  //     store (two addresses a cycle), forms the laplacian, then runs
  //     v*v, gain*v^2 and the two 32-bit halves of k*|lap| through one
  //     multiplier, rounds toward minus infinity and saturates
  // The result register parts the two sides: a new transfer is taken while
  // the previous result still waits downstream.

  awss_pkg::cmd_t cmd;
  awss_pkg::sts_t sts;

  // sequencer: clearing pass, then one item at a time
  awss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .sts         (sts),
    .point_stall (point_stall),
    .cmd         (cmd)
  );

  // stores, pointers, counters, arithmetic and the result register
  awss_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point        (point),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// File: dv/wave_step_checker.sv
// Result checker for the acoustic wave stencil step core.
// Tracks register writes and both channels, predicts each next-pressure
// result and compares it on transfer. Depends on awss_pkg only.
`timescale 1ns / 1ps
module wave_step_checker #(
  parameter int MAX_ROWS = awss_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = awss_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [awss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            point_valid,
  input  logic                            point_stall,
  input  awss_pkg::point_t                point,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  awss_pkg::result_t               result,
  output int                              fail_count,
  output int                              results_owed,
  output int                              points_held
);
  import awss_pkg::*;

  localparam int   LINE_SLOTS = 2 * MAX_ROWS + 2;
  localparam int   DELAY_SLOTS = MAX_ROWS + 1;

  logic [GAIN_W-1:0] gain_coef_q;
  logic [COLS_W-1:0] grid_cols_q;
  logic [ROWS_W-1:0] grid_rows_q;
  logic [THR_W-1:0]  threshold_q;

  logic signed [31:0] pressure_ring [LINE_SLOTS];
  logic signed [31:0] prev_ring [DELAY_SLOTS];
  logic [V_W-1:0]     speed_ring [DELAY_SLOTS];
  int                 line_wr, delay_wr, row_pos, col_pos, held;
  int                 mismatches = 0;
  result_t            next_pressure_q [$];

  assign fail_count  = mismatches;
  assign points_held = held;

  function automatic int rows_used();
    if (grid_rows_q < 3) return 3;
    if (grid_rows_q > MAX_ROWS) return MAX_ROWS;
    return int'(grid_rows_q);
  endfunction

  function automatic int cols_used();
    if (grid_cols_q < 3) return 3;
    if (grid_cols_q > MAX_COLS) return MAX_COLS;
    return int'(grid_cols_q);
  endfunction

  function automatic logic [32:0] abs33(logic signed [31:0] x);
    logic signed [32:0] w;
    w = 33'(x);
    if (w < 0) w = -w;
    return w;
  endfunction

  function automatic logic signed [31:0] line_at(int base, int off);
    int i;
    i = (base + off) % LINE_SLOTS;
    if (i < 0) i += LINE_SLOTS;
    return pressure_ring[i];
  endfunction

  // Compute the result of the oldest held point and advance its coordinates.
  function automatic result_t update_oldest_point();
    int                  rows, cols, c, d, t, x;
    logic signed [31:0]  p1, p2, dn, up, rt, lf;
    logic [32:0]         th;
    logic [63:0]         g, vv, k;
    logic signed [127:0] lap, prod, sum;
    result_t             r;
    rows = rows_used();
    cols = cols_used();
    c = (line_wr + LINE_SLOTS - held) % LINE_SLOTS;
    d = (delay_wr + DELAY_SLOTS - held) % DELAY_SLOTS;
    p1 = pressure_ring[c];
    p2 = prev_ring[d];
    vv = 64'(speed_ring[d]);
    t = row_pos;
    x = col_pos;
    sum = 128'(p1);
    if (t >= 1 && t + 2 <= rows && x >= 1 && x + 2 <= cols) begin
      dn = line_at(c, 1);
      up = line_at(c, -1);
      rt = line_at(c, rows);
      lf = line_at(c, -rows);
      th = {2'b00, threshold_q};
      if (abs33(p2) > th || abs33(dn) > th || abs33(up) > th ||
          abs33(rt) > th || abs33(lf) > th) begin
        lap = 128'(dn) + 128'(up) + 128'(rt) + 128'(lf) - (128'(p1) <<< 2);
        g = 64'(gain_coef_q);
        k = g * vv * vv;
        prod = $signed({64'd0, k}) * lap;
        sum = (prod >>> 48) + 128'(p1) + 128'(p1) - 128'(p2);
        if (sum > 128'sd2147483647) sum = 128'sd2147483647;
        else if (sum < -128'sd2147483648) sum = -128'sd2147483648;
      end
    end
    r.next_pressure = sum[31:0];
    r.grid_end = (t + 1 >= rows) && (x + 1 >= cols);
    if (t + 1 >= rows) begin
      row_pos = 0;
      col_pos = (x + 1 >= cols) ? 0 : x + 1;
    end else begin
      row_pos = t + 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t owed;
    if (rst) begin
      gain_coef_q = GAIN_RST;
      grid_cols_q = COLS_RST;
      grid_rows_q = ROWS_RST;
      threshold_q = THR_RST;
      for (int i = 0; i < LINE_SLOTS; i++) pressure_ring[i] = '0;
      line_wr = 0;
      delay_wr = 0;
      row_pos = 0;
      col_pos = 0;
      held = 0;
      next_pressure_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_COEF:        gain_coef_q = cfg_data[GAIN_W-1:0];
          CFG_GRID_COLS:        grid_cols_q = cfg_data[COLS_W-1:0];
          CFG_GRID_ROWS:        grid_rows_q = cfg_data[ROWS_W-1:0];
          CFG_ACTIVE_THRESHOLD: threshold_q = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (point_valid && !point_stall) begin
        if (point.func == FUNC_FLUSH) begin
          if (held > 0) begin
            owed = update_oldest_point();
            next_pressure_q = {next_pressure_q, owed};
            held--;
          end
        end else begin
          if (held >= rows_used() + 1) begin
            owed = update_oldest_point();
            next_pressure_q = {next_pressure_q, owed};
          end else begin
            held++;
          end
          pressure_ring[line_wr] = point.cur_pressure;
          prev_ring[delay_wr] = point.prev_pressure;
          speed_ring[delay_wr] = point.velocity;
          line_wr = (line_wr + 1) % LINE_SLOTS;
          delay_wr = (delay_wr + 1) % DELAY_SLOTS;
        end
      end
      if (result_valid && !result_stall) begin
        if (next_pressure_q.size() == 0) begin
          report_mismatch("result with nothing owed", result.next_pressure, '0);
        end else begin
          want = next_pressure_q.pop_front();
          if (result.next_pressure !== want.next_pressure)
            report_mismatch("next_pressure", result.next_pressure, want.next_pressure);
          if (result.grid_end !== want.grid_end)
            report_mismatch("grid_end", 32'(result.grid_end), 32'(want.grid_end));
        end
      end
    end
    results_owed = next_pressure_q.size();
  end

endmodule

// File: dv/tb_top.sv
// Top of the acoustic wave stencil step testbench: clock, reset, register
// programming, point/flush stimulus and result stalls. Depends on awss_pkg,
// acoustic_wave_stencil_step_core and wave_step_checker.
`timescale 1ns / 1ps
module tb_top;
  import awss_pkg::*;

  localparam int ITEM_TARGET     = 1050;
  localparam int HOLD_AT         = 800;   // earliest start of the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 16;    // a bit over one emitting item
  localparam int QUIET_LIMIT     = 20000; // covers the line store sweep after reset

  // Directed 3x4 grid: the two interior points see all-max and all-min
  // neighbors around an opposite-signed center, so both saturation rails hit.
  localparam logic [31:0] DIR_CUR [12] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h0100_0000, 32'h8000_0000, 32'h0000_0001};
  localparam logic [31:0] DIR_PREV [12] = '{
    32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
    32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000};
  localparam logic [15:0] DIR_VEL [12] = '{
    16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0,
    16'd340, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd1};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  point_valid = 1'b0;
  logic                  point_stall;
  point_t                point_item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result_item;

  int fail_count, results_owed, points_held;
  int items_sent = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 68;
  int quiet_cycles = 0;
  bit hold_off_req = 1'b0;

  always #5ns clk = ~clk;

  acoustic_wave_stencil_step_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_item)
  );

  wave_step_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_item),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .points_held  (points_held)
  );

  // Watchdog: end the run once nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if ((point_valid && !point_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls at the current rate; on request hold stall high
  // for a long stretch so the core backs up and stalls its input.
  always begin
    @(negedge clk);
    if (hold_off_req) begin
      result_stall <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clk);
      hold_off_req = 1'b0;
    end
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic logic [31:0] rand_pressure();
    case ($urandom_range(0, 7)) inside
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      [2:3]:   return $urandom;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  // Flush tick; the payload is don't-care, so fill it with noise.
  function automatic point_t flush_tick();
    point_t f;
    f.func = FUNC_FLUSH;
    f.cur_pressure = $urandom;
    f.prev_pressure = $urandom;
    f.velocity = 16'($urandom);
    return f;
  endfunction

  // Offer one item and hold it until the transfer. Idle rates follow the
  // progress of the run: sender-light, then receiver-light, then none.
  task automatic send_item(point_t item);
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle_pct = 38;
      recv_idle_pct = 68;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 68;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      point_valid <= 1'b0;
      @(negedge clk);
    end
    point_valid <= 1'b1;
    point_item <= item;
    do @(posedge clk); while (point_stall);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  // Write all four registers; bits above each register's width carry noise.
  task automatic program_grid(logic [31:0] gain, logic [12:0] cols, logic [10:0] rows,
                              logic [30:0] thr);
    write_reg(CFG_GAIN_COEF, gain);
    write_reg(CFG_GRID_COLS, ($urandom << COLS_W) | 32'(cols));
    write_reg(CFG_GRID_ROWS, ($urandom << ROWS_W) | 32'(rows));
    write_reg(CFG_ACTIVE_THRESHOLD, ($urandom & 32'h8000_0000) | 32'(thr));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Flush until the core holds no points.
  task automatic drain_block();
    @(negedge clk);
    while (points_held != 0) send_item(flush_tick());
  endtask

  // Drop valid, wait for every owed result, then let a fill item finish.
  task automatic settle();
    @(negedge clk);
    point_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    point_t      pt;
    logic [10:0] rows_cfg;
    logic [12:0] cols_cfg;
    logic [31:0] gain_cfg;
    logic [30:0] thr_cfg;
    int          rows_eff, cols_eff, total, phase_no;
    bit          hold_done;

    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty flush, a full 3x4 grid of extremes with flushes
    // before the grid is complete, then drain plus one more empty flush.
    program_grid(32'hFFFF_FFFF, 13'd4, 11'd3, '0);
    send_item(flush_tick());
    for (int i = 0; i < 12; i++) begin
      pt.func = FUNC_POINT;
      pt.cur_pressure = DIR_CUR[i];
      pt.prev_pressure = DIR_PREV[i];
      pt.velocity = DIR_VEL[i];
      send_item(pt);
      if (i == 2) begin
        send_item(flush_tick());
        send_item(flush_tick());
      end
    end
    drain_block();
    send_item(flush_tick());
    settle();

    // Random phases: mostly whole small grids with random content, some
    // cut short, some left undrained so the next sizes apply mid-stream.
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          rows_cfg = 11'($urandom_range(0, 2));
          cols_cfg = 13'($urandom_range(3, 5));
        end
        1: begin
          rows_cfg = 11'($urandom_range(3, 5));
          cols_cfg = 13'($urandom_range(0, 2));
        end
        2: begin
          rows_cfg = 11'($urandom_range(9, 16));
          cols_cfg = 13'd3;
        end
        default: begin
          rows_cfg = 11'($urandom_range(3, 8));
          cols_cfg = 13'($urandom_range(3, 6));
        end
      endcase
      case ($urandom_range(0, 5))
        0:       gain_cfg = '0;
        1:       gain_cfg = 32'hFFFF_FFFF;
        default: gain_cfg = $urandom >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 4))
        0:       thr_cfg = '0;
        1:       thr_cfg = 31'h7FFF_FFFF;
        2:       thr_cfg = 31'($urandom);
        default: thr_cfg = 31'($urandom_range(0, 32'h0300_0000));
      endcase
      // Largest sizes get only a short run of points each.
      if (phase_no == 3) begin
        rows_cfg = 11'd1024;
        cols_cfg = 13'd4096;
      end else if (phase_no == 6) begin
        rows_cfg = 11'h7FF;
        cols_cfg = 13'h1FFF;
      end
      program_grid(gain_cfg, cols_cfg, rows_cfg, thr_cfg);

      rows_eff = (rows_cfg < 3) ? 3 :
                 ((rows_cfg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_cfg));
      cols_eff = (cols_cfg < 3) ? 3 :
                 ((cols_cfg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_cfg));
      total = int'($urandom_range(1, 3)) * rows_eff * cols_eff;
      if (rows_eff > 64) total = 24;
      else if ($urandom_range(0, 4) == 0) total = int'($urandom_range(1, total - 1));

      for (int n = 0; n < total; n++) begin
        if ($urandom_range(0, 19) == 0) send_item(flush_tick());
        // Start the hold-off with a full pipe and a few points still to come,
        // so the result register fills and the input stalls.
        if (!hold_done && items_sent >= HOLD_AT && points_held >= rows_eff + 1 &&
            n + 3 <= total) begin
          hold_off_req = 1'b1;
          hold_done = 1'b1;
        end
        pt.func = FUNC_POINT;
        pt.cur_pressure = rand_pressure();
        pt.prev_pressure = rand_pressure();
        case ($urandom_range(0, 3))
          0:       pt.velocity = 16'($urandom_range(0, 65535));
          1:       pt.velocity = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: pt.velocity = 16'($urandom_range(300, 3000));
        endcase
        send_item(pt);
      end
      if (rows_eff > 64 || $urandom_range(0, 3) != 0) drain_block();
      settle();
      phase_no++;
    end

    drain_block();
    settle();
    if (fail_count == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/awss_pkg.sv
rtl/awss_ram.sv
rtl/awss_ctrl.sv
rtl/awss_dpath.sv
rtl/acoustic_wave_stencil_step_core.sv
dv/wave_step_checker.sv
dv/tb_top.sv
